/* rtl/core/usmd_pkg.sv */
// Shared types and constants for the unique source address detector.
package usmd_pkg;

  localparam int unsigned BUCKET_COUNT_DEF = 256;
  localparam int unsigned WAYS_PER_BUCKET_DEF = 4;

  localparam int unsigned MAC_W = 48;
  localparam int unsigned COUNT_W = 11;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic [7:0] PROBE_REQUEST_CODE = 8'h40;
  localparam logic signed [7:0] MIN_STRENGTH_RESET = -8'sd60;

  localparam logic REG_MIN_STRENGTH = 1'b0;

  typedef enum logic [1:0] {
    STATUS_IGNORED = 2'd0,
    STATUS_SEEN    = 2'd1,
    STATUS_NEW     = 2'd2,
    STATUS_FULL    = 2'd3
  } status_e;

  typedef struct packed {
    logic       considered;
    logic [7:0] bucket;
  } admit_t;

endpackage

/* rtl/core/usmd_admit.sv */
// Frame filter and bucket selection for the detector.
module usmd_admit #(
  parameter int unsigned BUCKET_COUNT = usmd_pkg::BUCKET_COUNT_DEF
) (
  input  logic               [7:0] frame_control_i,
  input  logic               [7:0] mac_top_i,
  input  logic signed        [7:0] signal_strength_i,
  input  logic signed        [7:0] min_strength_i,
  output usmd_pkg::admit_t         admit_o
);

  logic [7:0] bucket_lut [256];

  // first address byte modulo the bucket count, resolved at elaboration
  for (genvar g = 0; g < 256; g++) begin : g_lut
    assign bucket_lut[g] = 8'(g % BUCKET_COUNT);
  end

  always_comb begin
    admit_o.considered = (frame_control_i == usmd_pkg::PROBE_REQUEST_CODE) &&
                         (signal_strength_i >= min_strength_i);
    admit_o.bucket     = bucket_lut[mac_top_i];
  end

endmodule

/* rtl/core/unique_source_mac_detector.sv */
// Top level: unique source address detector with a hashed, way-limited tag store.
// An accepted frame goes straight to the output register if ignored, or, if considered,
// after a scan of the filled ways of its bucket, one tag compare per cycle on the single
// read port of the tag memory. The input is not ready again until the result is loaded
// into the output register. Asynchronous active-low reset clears the bucket fill valid
// bits and the unique count at once; tags stay unwritten.
module unique_source_mac_detector #(
  parameter int unsigned BUCKET_COUNT    = usmd_pkg::BUCKET_COUNT_DEF,
  parameter int unsigned WAYS_PER_BUCKET = usmd_pkg::WAYS_PER_BUCKET_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input frames
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // frame_control[7:0], source_mac[55:8], signal_strength[63:56]
  // results
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata   // status[1:0], reported_mac[49:2],
                                     // reported_strength[57:50], unique_count[68:58]
);

  localparam int unsigned IdxW   = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
  localparam int unsigned WayW   = (WAYS_PER_BUCKET > 1) ? $clog2(WAYS_PER_BUCKET) : 1;
  localparam int unsigned FillW  = $clog2(WAYS_PER_BUCKET + 1);
  localparam int unsigned Depth  = BUCKET_COUNT * WAYS_PER_BUCKET;
  localparam int unsigned AddrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned TagW   = (BUCKET_COUNT == 256) ? 40 : usmd_pkg::MAC_W;
  localparam int unsigned CountW = usmd_pkg::COUNT_W;
  localparam logic [FillW-1:0] WaysF = FillW'(WAYS_PER_BUCKET);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LOOK = 4'b0010,
    S_SCAN = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic signed [7:0] min_str_q;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == usmd_pkg::REG_MIN_STRENGTH);
  assign prdata = (paddr[2] == usmd_pkg::REG_MIN_STRENGTH) ? {24'd0, min_str_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_str_q <= usmd_pkg::MIN_STRENGTH_RESET;
    end else if (cfg_wr) begin
      min_str_q <= pwdata[7:0];
    end
  end

  // admission
  usmd_pkg::admit_t admit;
  logic             in_beat;

  usmd_admit #(
    .BUCKET_COUNT(BUCKET_COUNT)
  ) u_admit (
    .frame_control_i  (s_axis_tdata[7:0]),
    .mac_top_i        (s_axis_tdata[55:48]),
    .signal_strength_i(s_axis_tdata[63:56]),
    .min_strength_i   (min_str_q),
    .admit_o          (admit)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_beat       = s_axis_tvalid && s_axis_tready;

  // item registers
  logic [usmd_pkg::MAC_W-1:0] mac_q;
  logic [7:0]                 str_q;
  logic [IdxW-1:0]            bucket_q;
  usmd_pkg::status_e          status_q, status_d;
  logic [FillW-1:0]           fill_cnt_q, fill_cur;
  logic [WayW-1:0]            way_q;
  logic [FillW-1:0]           nxt_way;

  // fill counts: memory plus per-bucket valid bits
  logic [FillW-1:0]        fill_mem [BUCKET_COUNT];
  logic [BUCKET_COUNT-1:0] fill_vld_q;
  logic [FillW-1:0]        fill_rd_q;
  logic                    fill_vld_rd_q;

  // tag memory
  logic [TagW-1:0]  tag_mem [Depth];
  logic [TagW-1:0]  tag_rd_q;
  logic             tag_rd_en, tag_wr_en;
  logic [AddrW-1:0] base_addr, tag_rd_addr, tag_wr_addr;

  logic [CountW-1:0] total_q;
  logic              hit, last, insert;

  assign fill_cur  = fill_vld_rd_q ? fill_rd_q : '0;
  assign nxt_way   = FillW'(way_q) + FillW'(1);
  assign base_addr = AddrW'(bucket_q) * AddrW'(WAYS_PER_BUCKET);
  assign hit       = (tag_rd_q == mac_q[TagW-1:0]);
  assign last      = (nxt_way >= fill_cnt_q);

  always_comb begin
    state_d     = state_q;
    status_d    = status_q;
    tag_rd_en   = 1'b0;
    tag_rd_addr = base_addr;
    insert      = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_beat) begin
          status_d = usmd_pkg::STATUS_IGNORED;
          state_d  = admit.considered ? S_LOOK : S_DONE;
        end
      end
      S_LOOK: begin
        tag_rd_en = 1'b1;
        state_d   = S_SCAN;
      end
      S_SCAN: begin
        if ((fill_cnt_q != '0) && hit) begin
          status_d = usmd_pkg::STATUS_SEEN;
          state_d  = S_DONE;
        end else if (last) begin
          if (fill_cnt_q >= WaysF) begin
            status_d = usmd_pkg::STATUS_FULL;
          end else begin
            status_d = usmd_pkg::STATUS_NEW;
            insert   = 1'b1;
          end
          state_d = S_DONE;
        end else begin
          tag_rd_en   = 1'b1;
          tag_rd_addr = base_addr + AddrW'(nxt_way);
        end
      end
      S_DONE: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign tag_wr_en   = insert;
  assign tag_wr_addr = base_addr + AddrW'(fill_cnt_q[WayW-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      status_q   <= usmd_pkg::STATUS_IGNORED;
      fill_vld_q <= '0;
      total_q    <= '0;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
      if (insert) begin
        fill_vld_q[bucket_q] <= 1'b1;
        if (total_q != usmd_pkg::COUNT_MAX) begin
          total_q <= total_q + CountW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      mac_q         <= s_axis_tdata[55:8];
      str_q         <= s_axis_tdata[63:56];
      bucket_q      <= admit.bucket[IdxW-1:0];
      fill_rd_q     <= fill_mem[admit.bucket[IdxW-1:0]];
      fill_vld_rd_q <= fill_vld_q[admit.bucket[IdxW-1:0]];
    end
    if (state_q == S_LOOK) begin
      fill_cnt_q <= fill_cur;
      way_q      <= '0;
    end else if (tag_rd_en) begin
      way_q <= WayW'(nxt_way);
    end
    if (insert) begin
      fill_mem[bucket_q] <= fill_cnt_q + FillW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (tag_wr_en) begin
      tag_mem[tag_wr_addr] <= mac_q[TagW-1:0];
    end
    if (tag_rd_en) begin
      tag_rd_q <= tag_mem[tag_rd_addr];
    end
  end

  // output register
  logic                       m_vld_q;
  logic                       out_load;
  usmd_pkg::status_e          out_status_q;
  logic [usmd_pkg::MAC_W-1:0] out_mac_q;
  logic [7:0]                 out_str_q;
  logic [CountW-1:0]          out_cnt_q;

  assign out_load = (state_q == S_DONE) && (!m_vld_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
    end else if (out_load) begin
      m_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q <= status_q;
      out_mac_q    <= mac_q;
      out_str_q    <= str_q;
      out_cnt_q    <= total_q;
    end
  end

  assign m_axis_tvalid = m_vld_q;
  assign m_axis_tdata  = {3'd0, out_cnt_q, out_str_q, out_mac_q, out_status_q};

endmodule

/* tb/tb_unique_source_mac_detector.sv */
// Testbench for the unique source address detector: self-checking, with its own address table.
`timescale 1ns / 100ps

module tb_unique_source_mac_detector;
  import usmd_pkg::*;

  localparam int unsigned BUCKETS = BUCKET_COUNT_DEF;
  localparam int unsigned WAYS = WAYS_PER_BUCKET_DEF;
  localparam logic [2:0] MIN_STRENGTH_ADDR = {REG_MIN_STRENGTH, 2'b00};
  localparam int PHASES = 8;
  localparam int PHASE_FRAMES = 157;

  typedef struct packed {
    status_e            status;
    logic [MAC_W-1:0]   mac;
    logic signed [7:0]  strength;
    logic [COUNT_W-1:0] count;
  } frame_report_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;  // frame_control, source_mac, signal_strength
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;       // status, reported_mac, reported_strength, unique_count

  // address table copy
  logic [MAC_W-1:0]   tag_store [BUCKETS*WAYS];
  int unsigned        fill_level [BUCKETS];
  logic [COUNT_W-1:0] distinct_count;
  logic signed [7:0]  strength_floor;

  frame_report_t  pending_reports[$];
  logic [MAC_W-1:0] mac_history[$];
  int unsigned    mismatch_count = 0;

  bit tx_gaps_en = 1'b0;
  bit rx_stall_en = 1'b0;
  bit valid_held = 1'b0;
  int burst_left = 0;
  int ready_left = 0;
  int stall_left = 0;

  unique_source_mac_detector dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #6 clk_i = ~clk_i;

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic frame_report_t learn_address(logic [7:0] fc, logic [MAC_W-1:0] mac,
                                                  logic signed [7:0] rssi);
    frame_report_t rep;
    int unsigned   bucket;
    int unsigned   fill;
    bit            hit;
    rep.status   = STATUS_IGNORED;
    rep.mac      = mac;
    rep.strength = rssi;
    if (fc == PROBE_REQUEST_CODE && rssi >= strength_floor) begin
      bucket = mac[47:40] % BUCKETS;
      fill = fill_level[bucket];
      hit = 1'b0;
      for (int w = 0; w < fill; w++) begin
        if (tag_store[bucket*WAYS + w] == mac) hit = 1'b1;
      end
      if (hit) begin
        rep.status = STATUS_SEEN;
      end else if (fill >= WAYS) begin
        rep.status = STATUS_FULL;
      end else begin
        tag_store[bucket*WAYS + fill] = mac;
        fill_level[bucket] = fill + 1;
        if (distinct_count != COUNT_MAX) distinct_count++;
        rep.status = STATUS_NEW;
      end
    end
    rep.count = distinct_count;
    return rep;
  endfunction

  function automatic void check_field(string name, logic [63:0] exp, logic [63:0] act);
    if (act !== exp) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected 0x%0h actual 0x%0h", $time, name, exp, act);
    end
  endfunction

  // beat monitor: prediction on accepted inputs, checks on accepted results and APB reads
  always @(posedge clk_i) begin
    frame_report_t exp;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_reports.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result, expected none actual 0x%0h", $time, m_axis_tdata);
        end else begin
          exp = pending_reports.pop_front();
          check_field("status", 64'(exp.status), 64'(m_axis_tdata[1:0]));
          check_field("reported_mac", 64'(exp.mac), 64'(m_axis_tdata[49:2]));
          check_field("reported_strength", 64'($unsigned(exp.strength)),
                      64'(m_axis_tdata[57:50]));
          check_field("unique_count", 64'(exp.count), 64'(m_axis_tdata[68:58]));
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        pending_reports.push_back(learn_address(s_axis_tdata[7:0], s_axis_tdata[55:8],
                                                s_axis_tdata[63:56]));
      if (psel && penable && pready && paddr == MIN_STRENGTH_ADDR) begin
        if (pwrite) strength_floor = pwdata[7:0];
        else check_field("min_signal_strength", 64'($unsigned(strength_floor)),
                         64'(prdata[7:0]));
      end
    end
  end

  // receiver: always ready, or with stalls enabled ready runs alternating with stall runs
  always @(posedge clk_i) begin
    if (!rx_stall_en) begin
      m_axis_tready <= 1'b1;
    end else if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else if (ready_left > 0) begin
      m_axis_tready <= 1'b1;
      ready_left--;
    end else begin
      m_axis_tready <= 1'b1;
      ready_left = $urandom_range(0, 7);
      stall_left = $urandom_range(0, 5);
    end
  end

  task automatic send_frame(logic [7:0] fc, logic [MAC_W-1:0] mac, logic signed [7:0] rssi);
    s_axis_tdata  <= {rssi, mac, fc};
    s_axis_tvalid <= 1'b1;
    mac_history.push_back(mac);
    do @(posedge clk_i); while (!s_axis_tready);
    if (tx_gaps_en && burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      valid_held = 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = $urandom_range(1, 12);
    end else begin
      valid_held = 1'b1;
      if (burst_left > 0) burst_left--;
    end
  endtask

  // stop sending and wait for every outstanding result
  task automatic drain;
    if (valid_held) begin
      s_axis_tvalid <= 1'b0;
      valid_held = 1'b0;
    end
    @(posedge clk_i);
    while (pending_reports.size() != 0) @(posedge clk_i);
  endtask

  task automatic apb_access(bit wr, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= MIN_STRENGTH_ADDR;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_floor(logic signed [7:0] floor);
    drain();
    apb_access(1'b1, 32'(floor));
    apb_access(1'b0, '0);
  endtask

  task automatic test_default_threshold;
    apb_access(1'b0, '0);
    send_frame(PROBE_REQUEST_CODE, 48'h0, -8'sd60);
    send_frame(PROBE_REQUEST_CODE, 48'hFFFF_FFFF_FFFF, 8'sd127);
    send_frame(PROBE_REQUEST_CODE, 48'h0123_4567_89AB, -8'sd61);
    send_frame(8'h41, 48'h0123_4567_89AB, 8'sd0);
    send_frame(8'h00, 48'hAAAA_AAAA_AAAA, 8'sd0);
    send_frame(8'hFF, 48'h5555_5555_5555, 8'sd0);
    send_frame(8'hC0, 48'h0123_4567_89AB, 8'sd10);
    send_frame(PROBE_REQUEST_CODE, 48'hFFFF_FFFF_FFFF, -8'sd128);
    send_frame(PROBE_REQUEST_CODE, 48'h0, 8'sd0);
  endtask

  task automatic test_bucket_full;
    for (int i = 1; i <= WAYS + 1; i++)
      send_frame(PROBE_REQUEST_CODE, {8'h5A, 40'(i * 40'h11_0000_0001)}, -8'sd20);
    send_frame(PROBE_REQUEST_CODE, {8'h5A, 40'(2 * 40'h11_0000_0001)}, 8'sd5);
    send_frame(PROBE_REQUEST_CODE, {8'h5A, 40'((WAYS + 1) * 40'h11_0000_0001)}, 8'sd5);
  endtask

  task automatic test_threshold_extremes;
    set_floor(-8'sd128);
    send_frame(PROBE_REQUEST_CODE, 48'h8001_0203_0405, -8'sd128);
    set_floor(8'sd127);
    send_frame(PROBE_REQUEST_CODE, 48'h7F10_2030_4050, 8'sd126);
    send_frame(PROBE_REQUEST_CODE, 48'h7F10_2030_4050, 8'sd127);
    set_floor(MIN_STRENGTH_RESET);
  endtask

  task automatic test_random_traffic;
    logic signed [7:0] floor;
    logic [7:0]        fc;
    logic [MAC_W-1:0]  mac;
    logic signed [7:0] rssi;
    int                pick;
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: floor = -8'sd128;
        1: floor = 8'sd127;
        2: floor = -8'sd60;
        3: floor = -8'sd1;
        4: floor = 8'sd0;
        default: floor = 8'($urandom);
      endcase
      set_floor(floor);
      tx_gaps_en  = (p != 2);
      rx_stall_en = (p != 2);
      for (int n = 0; n < PHASE_FRAMES; n++) begin
        if (p == 4 && n == PHASE_FRAMES / 2) drain();
        fc = ($urandom_range(0, 9) < 8) ? PROBE_REQUEST_CODE : 8'($urandom);
        pick = $urandom_range(0, 9);
        if (pick < 6)
          mac = {8'($urandom_range(0, 15) * 17), 8'($urandom), 32'($urandom)};
        else if (pick < 8 || mac_history.size() == 0)
          mac = {16'($urandom), 32'($urandom)};
        else
          mac = mac_history[$urandom_range(0, mac_history.size() - 1)];
        if ($urandom_range(0, 3) != 0)
          rssi = 8'($urandom_range(int'(strength_floor) + 128, 255) - 128);
        else
          rssi = 8'($urandom);
        send_frame(fc, mac, rssi);
      end
    end
  endtask

  initial begin
    for (int b = 0; b < BUCKETS; b++) fill_level[b] = 0;
    distinct_count = '0;
    strength_floor = MIN_STRENGTH_RESET;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_default_threshold();
    test_bucket_full();
    test_threshold_extremes();
    test_random_traffic();
    drain();
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0 && pending_reports.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/usmd_pkg.sv
rtl/core/usmd_admit.sv
rtl/core/unique_source_mac_detector.sv
tb/tb_unique_source_mac_detector.sv
